[hw/rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd25;

   // command codes carried in the opcode field
   typedef enum logic [3:0] {
      OP_TICK    = 4'd0,
      OP_WR8     = 4'd1,
      OP_WR16    = 4'd2,
      OP_SETPTR  = 4'd3,
      OP_RD8     = 4'd4,
      OP_RD16    = 4'd5,
      OP_BURST   = 4'd6,
      OP_CURREAD = 4'd7,
      OP_PROBE   = 4'd8
   } op_type;

   // bus segments of one transaction
   typedef enum logic [3:0] {
      SEG_IDLE   = 4'd0,
      SEG_START  = 4'd1,
      SEG_ADDRW  = 4'd2,
      SEG_REG    = 4'd3,
      SEG_DHI    = 4'd4,
      SEG_DLO    = 4'd5,
      SEG_RSTART = 4'd6,
      SEG_ADDRR  = 4'd7,
      SEG_READ   = 4'd8,
      SEG_STOP   = 4'd9
   } seg_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [6:0]  device_addr;
      logic [7:0]  reg_addr;
      logic [15:0] write_data;
      logic [7:0]  read_count;
      logic        sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_driven;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic       last_byte;
      logic       done_res;
      logic       ack_ok;
      logic       rejected;
   } rsp_type;

   // segment that follows a finished one for the latched command
   function automatic seg_type next_seg(input seg_type seg, input logic [3:0] op);
      seg_type nxt;
      begin
         case (seg)
            SEG_START: begin
               nxt = (op == OP_CURREAD) ? SEG_ADDRR : SEG_ADDRW;
            end
            SEG_ADDRW: begin
               nxt = (op == OP_PROBE) ? SEG_STOP : SEG_REG;
            end
            SEG_REG: begin
               if (op == OP_WR8) begin
                  nxt = SEG_DLO;
               end else if (op == OP_WR16) begin
                  nxt = SEG_DHI;
               end else if (op == OP_SETPTR) begin
                  nxt = SEG_STOP;
               end else begin
                  nxt = SEG_RSTART;
               end
            end
            SEG_DHI:    nxt = SEG_DLO;
            SEG_RSTART: nxt = SEG_ADDRR;
            SEG_ADDRR:  nxt = SEG_READ;
            default:    nxt = SEG_STOP;
         endcase
         return nxt;
      end
   endfunction

endpackage

`default_nettype wire

[hw/rtl/i2c_master_register_access_core.sv]
// i2c master for register transactions, advanced one bus tick per req transfer
// req channel: each transfer is one tick; a command opcode while idle starts a
//   transaction (write byte/word, set pointer, read byte/word, burst, current
//   read, probe), opcode tick or unused codes just advance time
// rsp channel: exactly one transfer per req transfer, in order, carrying the
//   scl/sda drive for that tick, busy, any received byte and done with ack status
// csr channel: one write-only register, phase_ticks (ticks per bus phase);
//   csr_ready is always high, write it only while no transaction runs
// datapath: a req transfer lands in the input register, and the sequencer step is
//   written to the result register once rsp_stall no longer blocks it, which raises
//   rsp_valid (two register stages)
// throughput: one tick per clock while rsp_stall does not hold the result register
// stall: while a result waits under rsp_stall, one more item is held in the
//   input register, then req_stall goes high; nothing is dropped
// reset: bus idle (scl, sda high), phase_ticks back to 25, both registers empty
`default_nettype none

module i2c_master_register_access_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [6:0]  req_device_addr,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [15:0] req_write_data,
   input  wire logic [7:0]  req_read_count,
   input  wire logic        req_sda_sample,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_sda_driven,
   output logic             rsp_busy_res,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_last_byte,
   output logic             rsp_done_res,
   output logic             rsp_ack_ok,
   output logic             rsp_rejected,
   // configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_phase_ticks
);

   logic              in_valid_ff, in_valid_in;
   i2cm_pkg::req_type in_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::rsp_type rsp_ff, res;
   logic [7:0]        phase_ticks_ff;
   logic              out_blocked;
   logic              step;

   // result register full and not being taken
   assign out_blocked = rsp_valid_ff & rsp_stall;
   // sequencer advances when the input register holds an item and the result register can take its output
   assign step        = in_valid_ff & ~out_blocked;
   assign req_stall   = in_valid_ff & out_blocked;
   assign csr_ready   = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            phase_ticks_ff <= csr_phase_ticks;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff.opcode      <= req_opcode;
         in_ff.device_addr <= req_device_addr;
         in_ff.reg_addr    <= req_reg_addr;
         in_ff.write_data  <= req_write_data;
         in_ff.read_count  <= req_read_count;
         in_ff.sda_sample  <= req_sda_sample;
      end
   end

   // transaction sequencer, one tick per step
   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (in_ff),
      .phase_ticks (phase_ticks_ff),
      .res         (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = rsp_ff.scl_level;
   assign rsp_sda_level  = rsp_ff.sda_level;
   assign rsp_sda_driven = rsp_ff.sda_driven;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_read_byte  = rsp_ff.read_byte;
   assign rsp_last_byte  = rsp_ff.last_byte;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_ack_ok     = rsp_ff.ack_ok;
   assign rsp_rejected   = rsp_ff.rejected;

endmodule

`default_nettype wire

[hw/rtl/i2cm_seq.sv]
`default_nettype none

// bus sequencer: holds the transaction state, advances one tick per step
module i2cm_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire i2cm_pkg::req_type req,
   input  wire logic [7:0]        phase_ticks,
   output i2cm_pkg::rsp_type      res
);

   i2cm_pkg::seg_type seg_ff, seg_in, target;
   logic        half_ff, half_in;
   logic [7:0]  tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  op_ff, op_in;
   logic [6:0]  addr_ff, addr_in;
   logic [7:0]  reg_ff, reg_in;
   logic [15:0] data_ff, data_in;
   logic [7:0]  count_ff, count_in;
   logic        ack_all_ff, ack_all_in;
   logic        ack_seen_ff, ack_seen_in;

   logic       is_cmd;
   logic       enter;
   logic       phase_end;
   logic       is_rd;
   logic       final_byte;
   logic [1:0] sub;

   always_comb begin
      seg_in      = seg_ff;
      half_in     = half_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      byte_in     = byte_ff;
      shift_in    = shift_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      reg_in      = reg_ff;
      data_in     = data_ff;
      count_in    = count_ff;
      ack_all_in  = ack_all_ff;
      ack_seen_in = ack_seen_ff;
      enter       = 1'b0;
      target      = i2cm_pkg::SEG_IDLE;
      phase_end   = 1'b0;
      is_rd       = 1'b0;
      final_byte  = 1'b0;
      sub         = 2'd0;
      res            = '0;
      res.scl_level  = 1'b1;
      res.sda_level  = 1'b1;
      res.sda_driven = 1'b1;

      is_cmd = (req.opcode >= i2cm_pkg::OP_WR8) && (req.opcode <= i2cm_pkg::OP_PROBE);

      // command latch, the command tick is the first tick of the start
      if (seg_ff == i2cm_pkg::SEG_IDLE) begin
         if (is_cmd) begin
            op_in   = req.opcode;
            addr_in = req.device_addr;
            reg_in  = req.reg_addr;
            data_in = req.write_data;
            if (req.opcode == i2cm_pkg::OP_RD8) begin
               count_in = 8'd1;
            end else if (req.opcode == i2cm_pkg::OP_RD16) begin
               count_in = 8'd2;
            end else begin
               count_in = req.read_count;
            end
            if (count_in == 8'd0) begin
               count_in = 8'd1;
            end
            byte_in     = 8'd0;
            ack_all_in  = 1'b1;
            seg_in      = i2cm_pkg::SEG_START;
            half_in     = 1'b0;
            bit_in      = 4'd1;
            tick_in     = 8'd0;
            ack_seen_in = 1'b0;
         end
      end else if (is_cmd) begin
         res.rejected = 1'b1;
      end

      if (seg_in != i2cm_pkg::SEG_IDLE) begin
         phase_end    = ({1'b0, tick_in} + 9'd1) >= {1'b0, phase_ticks};
         res.busy_res = 1'b1;
         case (seg_in)
            i2cm_pkg::SEG_START, i2cm_pkg::SEG_RSTART: begin
               sub           = bit_in[1:0];
               res.scl_level = (sub == 2'd1) || (sub == 2'd2);
               res.sda_level = (sub < 2'd2);
               if (phase_end) begin
                  if (sub < 2'd3) begin
                     bit_in  = {2'b00, sub} + 4'd1;
                     tick_in = 8'd0;
                  end else begin
                     enter  = 1'b1;
                     target = i2cm_pkg::next_seg(seg_in, op_in);
                  end
               end else begin
                  tick_in = tick_in + 8'd1;
               end
            end
            i2cm_pkg::SEG_STOP: begin
               sub           = (bit_in > 4'd2) ? 2'd2 : bit_in[1:0];
               res.scl_level = (sub >= 2'd1);
               res.sda_level = (sub == 2'd2);
               if (phase_end) begin
                  if (sub < 2'd2) begin
                     bit_in  = {2'b00, sub} + 4'd1;
                     tick_in = 8'd0;
                  end else begin
                     res.done_res = 1'b1;
                     res.ack_ok   = ack_all_in;
                     enter        = 1'b1;
                     target       = i2cm_pkg::SEG_IDLE;
                  end
               end else begin
                  tick_in = tick_in + 8'd1;
               end
            end
            default: begin
               // byte segments: eight data bits then the ack bit
               is_rd         = (seg_in == i2cm_pkg::SEG_READ);
               final_byte    = ({1'b0, byte_in} + 9'd1) >= {1'b0, count_in};
               res.scl_level = half_in;
               if (bit_in < 4'd8) begin
                  if (is_rd) begin
                     res.sda_driven = 1'b0;
                     res.sda_level  = 1'b1;
                     if (half_in && (tick_in == 8'd0)) begin
                        shift_in = {shift_in[6:0], req.sda_sample};
                        if (bit_in == 4'd7) begin
                           res.byte_valid = 1'b1;
                           res.read_byte  = shift_in;
                           res.last_byte  = final_byte;
                        end
                     end
                  end else begin
                     res.sda_driven = 1'b1;
                     res.sda_level  = shift_in[3'd7 - bit_in[2:0]];
                  end
               end else if (is_rd) begin
                  // master ack, nack on the last byte
                  res.sda_driven = 1'b1;
                  res.sda_level  = final_byte;
               end else begin
                  res.sda_driven = 1'b0;
                  res.sda_level  = 1'b1;
                  if (half_in && !req.sda_sample) begin
                     ack_seen_in = 1'b1;
                  end
               end
               if (phase_end) begin
                  tick_in = 8'd0;
                  if (!half_in) begin
                     half_in = 1'b1;
                  end else if (bit_in < 4'd8) begin
                     half_in = 1'b0;
                     bit_in  = bit_in + 4'd1;
                  end else if (is_rd) begin
                     byte_in = byte_in + 8'd1;
                     enter   = 1'b1;
                     target  = (byte_in >= count_in) ? i2cm_pkg::SEG_STOP
                                                     : i2cm_pkg::SEG_READ;
                  end else begin
                     if (!ack_seen_in) begin
                        ack_all_in = 1'b0;
                     end
                     enter  = 1'b1;
                     target = i2cm_pkg::next_seg(seg_in, op_in);
                  end
               end else begin
                  tick_in = tick_in + 8'd1;
               end
            end
         endcase
      end

      // segment entry clears the bit state and loads the shifter for byte segments
      if (enter) begin
         seg_in      = target;
         half_in     = 1'b0;
         bit_in      = 4'd0;
         tick_in     = 8'd0;
         ack_seen_in = 1'b0;
         case (target)
            i2cm_pkg::SEG_ADDRW: shift_in = {addr_in, 1'b0};
            i2cm_pkg::SEG_ADDRR: shift_in = {addr_in, 1'b1};
            i2cm_pkg::SEG_REG:   shift_in = reg_in;
            i2cm_pkg::SEG_DHI:   shift_in = data_in[15:8];
            i2cm_pkg::SEG_DLO:   shift_in = data_in[7:0];
            i2cm_pkg::SEG_READ:  shift_in = 8'd0;
            default:             shift_in = shift_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff      <= i2cm_pkg::SEG_IDLE;
         half_ff     <= 1'b0;
         tick_ff     <= 8'd0;
         bit_ff      <= 4'd0;
         byte_ff     <= 8'd0;
         ack_all_ff  <= 1'b1;
         ack_seen_ff <= 1'b0;
      end else if (step) begin
         seg_ff      <= seg_in;
         half_ff     <= half_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         byte_ff     <= byte_in;
         ack_all_ff  <= ack_all_in;
         ack_seen_ff <= ack_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff <= shift_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         reg_ff   <= reg_in;
         data_ff  <= data_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/i2cm_checker.sv]
`default_nettype none

module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_scl_level,
   input wire logic       rsp_sda_level,
   input wire logic       rsp_sda_driven,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_byte_valid,
   input wire logic [7:0] rsp_read_byte,
   input wire logic       rsp_last_byte,
   input wire logic       rsp_done_res,
   input wire logic       rsp_ack_ok
);

   // ack status only with done
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_ack_ok && (!rsp_done_res || rsp_busy_res))
      else $error("ack_ok without done");

   // idle bus is driven high and quiet
   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |->
         rsp_scl_level && rsp_sda_level && rsp_sda_driven && !rsp_byte_valid && !rsp_done_res)
      else $error("idle tick drives the bus");

   // received byte only while master releases sda, no stale byte fields
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_read_byte == 8'd0 && !rsp_last_byte)
      else $error("byte fields set without byte_valid");

   a_byte_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_sda_driven && rsp_scl_level && rsp_busy_res)
      else $error("byte reported outside a read sample");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte) && $stable(rsp_done_res))
      else $error("stalled result changed");

endmodule

bind i2c_master_register_access_core i2cm_checker u_i2cm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_scl_level  (rsp_scl_level),
   .rsp_sda_level  (rsp_sda_level),
   .rsp_sda_driven (rsp_sda_driven),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_read_byte  (rsp_read_byte),
   .rsp_last_byte  (rsp_last_byte),
   .rsp_done_res   (rsp_done_res),
   .rsp_ack_ok     (rsp_ack_ok)
);

`default_nettype wire
